// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset
`define ASSERT_IMPLIES(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication under synchronous active-low reset
`define ASSERT_NEXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/fsbme_pkg.sv =====
package fsbme_pkg;

  // block and window geometry
  localparam int BLK      = 4;
  localparam int SR       = 16;
  localparam int LWIN     = 2 * SR + BLK;
  localparam int CWIN     = SR + 2;
  localparam int CORG     = SR / 2;
  localparam int NPOS     = BLK * BLK;
  localparam int NOUT     = 24;
  localparam int LDEPTH   = LWIN * LWIN;
  localparam int CDEPTH   = 2 * CWIN * CWIN;
  localparam int LADDR_W  = $clog2(LDEPTH);
  localparam int CADDR_W  = $clog2(CDEPTH);
  localparam int COST_W   = 14;

  localparam logic [COST_W-1:0] NO_COST = 14'h3FFF;

  // plane codes
  localparam logic [1:0] PL_Y  = 2'd0;
  localparam logic [1:0] PL_CB = 2'd1;
  localparam logic [1:0] PL_CR = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD_CUR = 2'd0,
    ACT_LOAD_WIN = 2'd1,
    ACT_START    = 2'd2,
    ACT_NOP      = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // partial cost travelling down the cell chain
  typedef struct packed {
    logic              vld;
    logic              lastc;
    logic [COST_W-1:0] sum;
    logic [5:0]        dy;
    logic [5:0]        dx;
  } link_t;

  // current-block sample load, broadcast to every cell
  typedef struct packed {
    logic       we;
    logic [1:0] plane;
    logic [1:0] row;
    logic [1:0] col;
    logic [7:0] pix;
  } cur_load_t;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  // row*36 + col
  function automatic logic [LADDR_W-1:0] luma_addr(input logic [5:0] r, input logic [5:0] c);
    luma_addr = {r, 5'b0} + {3'b0, r, 2'b0} + {5'b0, c};
  endfunction

  // plane*324 + row*18 + col
  function automatic logic [CADDR_W-1:0] chroma_addr(input logic p, input logic [4:0] r,
                                                     input logic [4:0] c);
    chroma_addr = (p ? 10'd324 : 10'd0) + {1'b0, r, 4'b0} + {4'b0, r, 1'b0} + {5'b0, c};
  endfunction

endpackage

// ===== rtl/core/fsbme_cell.sv =====
module fsbme_cell
  import fsbme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic [3:0] pos,
  input  cur_load_t ld,
  input  logic [7:0] ref_y,
  input  logic [7:0] ref_cb,
  input  logic [7:0] ref_cr,
  input  link_t     link_i,
  output link_t     link_o
);

  logic [7:0] cur_y_r, cur_cb_r, cur_cr_r;
  link_t      link_r, link_nxt;

  // current samples owned by this position (chroma at half resolution)
  always_ff @(posedge clk) begin
    if (ld.we) begin
      if (ld.plane == PL_Y && {ld.row, ld.col} == pos) cur_y_r <= ld.pix;
      if (ld.plane == PL_CB && ld.row[0] == pos[3] && ld.col[0] == pos[1]) cur_cb_r <= ld.pix;
      if (ld.plane == PL_CR && ld.row[0] == pos[3] && ld.col[0] == pos[1]) cur_cr_r <= ld.pix;
    end
  end

  // add this position's luma and chroma differences
  always_comb begin
    link_nxt     = link_i;
    link_nxt.sum = link_i.sum + {6'b0, absdiff(cur_y_r, ref_y)}
                 + {6'b0, absdiff(cur_cb_r, ref_cb)} + {6'b0, absdiff(cur_cr_r, ref_cr)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.vld <= 1'b0;
    end else begin
      link_r.vld <= link_i.vld;
    end
    if (link_i.vld) begin
      link_r.lastc <= link_nxt.lastc;
      link_r.sum   <= link_nxt.sum;
      link_r.dy    <= link_nxt.dy;
      link_r.dx    <= link_nxt.dx;
    end
  end

  assign link_o = link_r;

endmodule

// ===== rtl/core/fsbme_chain.sv =====
module fsbme_chain
  import fsbme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cur_load_t ld,
  input  logic [7:0] ref_y,
  input  logic [7:0] ref_cb,
  input  logic [7:0] ref_cr,
  input  link_t     head,
  output link_t     tail
);

  link_t link_w [0:NPOS];

  assign link_w[0] = head;

  // one cell per block position; the sum reaches cell k with sample k
  for (genvar i = 0; i < NPOS; i++) begin : g_cell
    fsbme_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .pos    (4'(i)),
      .ld     (ld),
      .ref_y  (ref_y),
      .ref_cb (ref_cb),
      .ref_cr (ref_cr),
      .link_i (link_w[i]),
      .link_o (link_w[i+1])
    );
  end

  assign tail = link_w[NPOS];

endmodule

// ===== rtl/core/full_search_block_motion_estimation_unit.sv =====
// Channel | Dir | Beat contents
// in_     | in  | tuser: action[1:0] plane[3:2]; tdata: win_row win_col pixel block_row block_col
// out_    | out | tuser: out_plane; tdata: mv_x mv_y best_cost out_row out_col pred_sample; tlast
// cfg_    | in  | cfg_addr: 0 frame_block_rows, 1 frame_block_cols; cfg_data 11 bits
// Loads are accepted back to back while idle. A search walks every candidate offset
// with one window read per cycle through the single luma read port, then drains the
// 16-cell chain until the last sum leaves it. Each of the 24 result beats is read,
// then loaded into the output register. in_tready is low from a start beat until the
// last result beat is taken. Reset loads 72 and 88 into the frame registers; window
// stores are not cleared.
module full_search_block_motion_estimation_unit
  import fsbme_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3:0]  in_tuser,   // action[1:0], plane[3:2]
  input  logic [39:0] in_tdata,   // win_row[5:0] win_col[11:6] pixel[19:12]
                                  // block_row[29:20] block_col[39:30]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // out_plane[1:0]
  output logic [39:0] out_tdata,  // mv_x[5:0] mv_y[11:6] best_cost[25:12]
                                  // out_row[27:26] out_col[29:28] pred_sample[37:30]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_data
);

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // input beat fields
  logic [1:0] in_action, in_plane;
  logic [5:0] in_win_row, in_win_col;
  logic [7:0] in_pixel;
  logic [9:0] in_block_row, in_block_col;
  logic       in_acc;

  assign in_action    = in_tuser[1:0];
  assign in_plane     = in_tuser[3:2];
  assign in_win_row   = in_tdata[5:0];
  assign in_win_col   = in_tdata[11:6];
  assign in_pixel     = in_tdata[19:12];
  assign in_block_row = in_tdata[29:20];
  assign in_block_col = in_tdata[39:30];
  assign in_acc       = in_tvalid && in_tready;

  // frame size registers
  logic [10:0] rows_r, cols_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 11'd72;
      cols_r <= 11'd88;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_ROWS: rows_r <= cfg_data;
        CFG_COLS: cols_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  state_t state_r, state_nxt;

  logic signed [5:0] dy_r, dx_r, lo_x_r, hi_x_r, hi_y_r;
  logic [3:0]  k_r;
  logic        found_r;
  logic [COST_W-1:0] best_sad_r;
  logic [5:0]  best_dy_r, best_dx_r;
  logic [4:0]  e_r, pend_e_r;
  logic        rd_pend_r;
  logic        tag_vld_r, tag_last_r;
  logic [3:0]  tag_k_r;
  logic [5:0]  tag_dy_r, tag_dx_r;
  logic        out_vld_r, out_last_r;
  logic [1:0]  out_plane_r, out_row_r, out_col_r;
  logic [7:0]  out_pix_r;
  logic [7:0]  y_q_r, cb_q_r, cr_q_r;

  // search bounds at start
  logic signed [14:0] ycur_s, xcur_s, lo_y_s, lo_x_s, hi_y_s, hi_x_s, hy_raw, hx_raw;
  logic               empty;
  always_comb begin
    ycur_s = $signed({3'b000, in_block_row, 2'b00});
    xcur_s = $signed({3'b000, in_block_col, 2'b00});
    lo_y_s = (ycur_s > 15'sd16) ? -15'sd16 : -ycur_s;
    lo_x_s = (xcur_s > 15'sd16) ? -15'sd16 : -xcur_s;
    hy_raw = $signed({2'b00, rows_r, 2'b00}) - ycur_s - 15'sd4;
    hx_raw = $signed({2'b00, cols_r, 2'b00}) - xcur_s - 15'sd4;
    hi_y_s = (hy_raw > 15'sd16) ? 15'sd16 : hy_raw;
    hi_x_s = (hx_raw > 15'sd16) ? 15'sd16 : hx_raw;
    empty  = (lo_y_s > hi_y_s) || (lo_x_s > hi_x_s);
  end

  logic start_acc, last_cand, search_end, emit_issue;
  link_t chain_head, chain_tail;

  assign start_acc  = in_acc && in_action == ACT_START;
  assign last_cand  = dx_r == hi_x_r && dy_r == hi_y_r;
  assign search_end = k_r == 4'd15 && last_cand;
  assign emit_issue = state_r == ST_EMIT && e_r < 5'(NOUT) && !rd_pend_r
                      && (!out_vld_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start_acc) state_nxt = empty ? ST_EMIT : ST_SEARCH;
      ST_SEARCH: if (search_end) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (chain_tail.vld && chain_tail.lastc) state_nxt = ST_EMIT;
      ST_EMIT:   if (out_vld_r && out_tready && out_last_r) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // handshake outputs
  always_comb begin
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      default: in_tready = 1'b0;
    endcase
  end

  // current-block loads into the cells
  cur_load_t cur_ld;
  always_comb begin
    cur_ld.plane = in_plane;
    cur_ld.row   = in_win_row[1:0];
    cur_ld.col   = in_win_col[1:0];
    cur_ld.pix   = in_pixel;
    cur_ld.we    = in_acc && in_action == ACT_LOAD_CUR &&
                   ((in_plane == PL_Y && in_win_row < 6'd4 && in_win_col < 6'd4) ||
                    ((in_plane == PL_CB || in_plane == PL_CR) &&
                     in_win_row < 6'd2 && in_win_col < 6'd2));
  end

  // window stores
  logic [7:0] mem_y [0:LDEPTH-1];
  logic [7:0] mem_c [0:CDEPTH-1];
  logic       y_we, c_we;
  logic [LADDR_W-1:0] y_waddr, y_raddr;
  logic [CADDR_W-1:0] c_waddr, c_raddr0, c_raddr1;

  assign y_we    = in_acc && in_action == ACT_LOAD_WIN && in_plane == PL_Y &&
                   in_win_row < 6'(LWIN) && in_win_col < 6'(LWIN);
  assign c_we    = in_acc && in_action == ACT_LOAD_WIN &&
                   (in_plane == PL_CB || in_plane == PL_CR) &&
                   in_win_row < 6'(CWIN) && in_win_col < 6'(CWIN);
  assign y_waddr = luma_addr(in_win_row, in_win_col);
  assign c_waddr = chroma_addr(in_plane == PL_CR, in_win_row[4:0], in_win_col[4:0]);

  always_ff @(posedge clk) begin
    if (y_we) mem_y[y_waddr] <= in_pixel;
    y_q_r <= mem_y[y_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) mem_c[c_waddr] <= in_pixel;
    cb_q_r <= mem_c[c_raddr0];
    cr_q_r <= mem_c[c_raddr1];
  end

  // read addresses: search walks (dy,dx,k), emission walks e
  logic [5:0] s_ry, s_cx_l, s_cy, s_cx, e_ry, e_rx, ty, tx, e_cy, e_cx;
  always_comb begin
    s_ry   = dy_r + 6'd16 + {4'b0, k_r[3:2]};
    s_cx_l = dx_r + 6'd16 + {4'b0, k_r[1:0]};
    s_cy   = {dy_r[5], dy_r[5:1]} + 6'(CORG) + {5'b0, k_r[3]};
    s_cx   = {dx_r[5], dx_r[5:1]} + 6'(CORG) + {5'b0, k_r[1]};
    e_ry   = best_dy_r + 6'd16 + {4'b0, e_r[3:2]};
    e_rx   = best_dx_r + 6'd16 + {4'b0, e_r[1:0]};
    ty     = best_dy_r + {5'b0, best_dy_r[5]};
    tx     = best_dx_r + {5'b0, best_dx_r[5]};
    e_cy   = {ty[5], ty[5:1]} + 6'(CORG) + {5'b0, e_r[1]};
    e_cx   = {tx[5], tx[5:1]} + 6'(CORG) + {5'b0, e_r[0]};
    if (state_r == ST_EMIT) begin
      y_raddr  = luma_addr(e_ry, e_rx);
      c_raddr0 = chroma_addr(e_r[2], e_cy[4:0], e_cx[4:0]);
    end else begin
      y_raddr  = luma_addr(s_ry, s_cx_l);
      c_raddr0 = chroma_addr(1'b0, s_cy[4:0], s_cx[4:0]);
    end
    c_raddr1 = chroma_addr(1'b1, s_cy[4:0], s_cx[4:0]);
  end

  // candidate walk and read tags
  always_ff @(posedge clk) begin
    if (start_acc) begin
      dy_r   <= lo_y_s[5:0];
      dx_r   <= lo_x_s[5:0];
      lo_x_r <= lo_x_s[5:0];
      hi_x_r <= hi_x_s[5:0];
      hi_y_r <= hi_y_s[5:0];
      k_r    <= 4'd0;
    end else if (state_r == ST_SEARCH) begin
      k_r <= k_r + 4'd1;
      if (k_r == 4'd15) begin
        if (dx_r == hi_x_r) begin
          dx_r <= lo_x_r;
          dy_r <= dy_r + 6'sd1;
        end else begin
          dx_r <= dx_r + 6'sd1;
        end
      end
    end
    tag_k_r    <= k_r;
    tag_last_r <= last_cand;
    tag_dy_r   <= dy_r;
    tag_dx_r   <= dx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tag_vld_r <= 1'b0;
    else        tag_vld_r <= state_r == ST_SEARCH;
  end

  // cell chain
  always_comb begin
    chain_head.vld   = tag_vld_r && tag_k_r == 4'd0;
    chain_head.lastc = tag_last_r;
    chain_head.sum   = '0;
    chain_head.dy    = tag_dy_r;
    chain_head.dx    = tag_dx_r;
  end

  fsbme_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld     (cur_ld),
    .ref_y  (y_q_r),
    .ref_cb (cb_q_r),
    .ref_cr (cr_q_r),
    .head   (chain_head),
    .tail   (chain_tail)
  );

  // best candidate, first strict minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      best_sad_r <= '0;
      best_dy_r  <= '0;
      best_dx_r  <= '0;
    end else if (start_acc) begin
      found_r    <= 1'b0;
      best_sad_r <= NO_COST;
      best_dy_r  <= '0;
      best_dx_r  <= '0;
    end else if (chain_tail.vld && (!found_r || chain_tail.sum < best_sad_r)) begin
      found_r    <= 1'b1;
      best_sad_r <= chain_tail.sum;
      best_dy_r  <= chain_tail.dy;
      best_dx_r  <= chain_tail.dx;
    end
  end

  // emission: read one sample, then load the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r       <= '0;
      rd_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (start_acc)       e_r <= '0;
      else if (emit_issue) e_r <= e_r + 5'd1;
      rd_pend_r <= emit_issue;
      if (rd_pend_r)       out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_issue) pend_e_r <= e_r;
    if (rd_pend_r) begin
      out_last_r <= pend_e_r == 5'(NOUT - 1);
      if (pend_e_r < 5'(NPOS)) begin
        out_plane_r <= PL_Y;
        out_row_r   <= pend_e_r[3:2];
        out_col_r   <= pend_e_r[1:0];
        out_pix_r   <= y_q_r;
      end else begin
        out_plane_r <= pend_e_r[2] ? PL_CR : PL_CB;
        out_row_r   <= {1'b0, pend_e_r[1]};
        out_col_r   <= {1'b0, pend_e_r[0]};
        out_pix_r   <= cb_q_r;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_plane_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_pix_r, out_col_r, out_row_r, best_sad_r,
                       best_dy_r, best_dx_r};

endmodule

// ===== rtl/core/fsbme_checker.sv =====
`include "assert_macros.svh"

module fsbme_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [3:0]  in_tuser,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [1:0]  out_tuser,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_addr,
  input logic [10:0] cfg_data
);

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // no input beat taken while results are pending
  `ASSERT_IMPLIES(a_busy, clk, rst_n, out_tvalid, !in_tready)
  // the final beat is the last Cr sample
  `ASSERT_IMPLIES(a_last, clk, rst_n, out_tvalid && out_tlast, out_tuser == 2'd2 && out_tdata[27:26] == 2'd1 && out_tdata[29:28] == 2'd1)
  // vector stays within the search range
  `ASSERT_IMPLIES(a_mv, clk, rst_n, out_tvalid, $signed(out_tdata[5:0]) >= -6'sd16 && $signed(out_tdata[5:0]) <= 6'sd16 && $signed(out_tdata[11:6]) >= -6'sd16 && $signed(out_tdata[11:6]) <= 6'sd16)

endmodule

bind full_search_block_motion_estimation_unit fsbme_props u_fsbme_props (.*);
